@@ rtl/core/llst_pkg.sv @@
package llst_pkg;

  // table geometry
  localparam int ROWS    = 512;
  localparam int BUCKETS = 65;
  localparam int NMET    = 3;
  localparam int SLOTS   = ROWS * NMET;
  localparam int HDEPTH  = SLOTS * BUCKETS;

  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int HIST_AW = $clog2(HDEPTH);
  localparam int BK_W    = $clog2(BUCKETS);

  // field widths
  localparam int OP_W     = 2;
  localparam int ROW_W    = 9;
  localparam int NS_W     = 64;
  localparam int DEPTH_W  = 16;
  localparam int MSEL_W   = 2;
  localparam int PCT_W    = 7;
  localparam int PROD_W   = NS_W + PCT_W;
  localparam int BLEN_W   = 7;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 592;

  // operation codes
  localparam logic [OP_W-1:0] OP_RECORD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TRYFAIL = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // metric codes
  localparam logic [MSEL_W-1:0] MET_WAIT = 2'd0;
  localparam logic [MSEL_W-1:0] MET_HOLD = 2'd1;
  localparam logic [MSEL_W-1:0] MET_REC  = 2'd2;

  // count * percent above this means the target does not fit in 64 bits
  localparam logic [PROD_W-1:0] HUGE_LIM =
    PROD_W'(64'hFFFF_FFFF_FFFF_FFFF) * PROD_W'(100);

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clr_step;
    logic set_metric_first;
    logic set_metric_wait;
    logic bl_stage;
    logic bk_stage;
    logic base_ld;
    logic ctr_rd;
    logic tot_rd;
    logic hist_rd_bk;
    logic hist_rd_walk;
    logic ctr_wr_rec;
    logic ctr_wr_fail;
    logic met_wr;
    logic walk_init;
    logic walk_acc;
    logic walk_next;
    logic prod_ld;
    logic pct_zero;
    logic pct_max;
    logic pct_bucket;
    logic out_load;
  } llst_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            row_ok;
    logic            rec;
    logic            cont;
    logic            metric_ok;
    logic            cnt_zero;
    logic            huge;
    logic            hit;
    logic            bidx_last;
    logic            out_free;
  } llst_sts_t;

endpackage

@@ rtl/core/llst_ctrl.sv @@
module llst_ctrl
  import llst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output llst_cmd_t cmd,
  input  llst_sts_t sts
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_R_BL  = 4'd3;
  localparam logic [3:0] S_R_BK  = 4'd4;
  localparam logic [3:0] S_R_RD  = 4'd5;
  localparam logic [3:0] S_R_WR  = 4'd6;
  localparam logic [3:0] S_F_RD  = 4'd7;
  localparam logic [3:0] S_F_WR  = 4'd8;
  localparam logic [3:0] S_Q_RD  = 4'd9;
  localparam logic [3:0] S_Q_LD  = 4'd10;
  localparam logic [3:0] S_Q_CHK = 4'd11;
  localparam logic [3:0] S_W_ACC = 4'd12;
  localparam logic [3:0] S_W_CMP = 4'd13;
  localparam logic [3:0] S_Q_OUT = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       second_r, second_nxt;

  assign in_tready = (state_r == S_IDLE);

  // state and pass registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    second_nxt = second_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op)
          OP_RECORD: begin
            if (sts.row_ok) begin
              cmd.set_metric_first = 1'b1;
              second_nxt           = 1'b0;
              state_nxt            = S_R_BL;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          OP_TRYFAIL: state_nxt = sts.row_ok ? S_F_RD : S_IDLE;
          OP_QUERY: begin
            if (sts.row_ok) begin
              cmd.set_metric_first = 1'b1;
              state_nxt            = S_Q_RD;
            end else begin
              state_nxt = S_Q_OUT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // record: one pass per metric touched
      S_R_BL: begin
        cmd.bl_stage = 1'b1;
        cmd.base_ld  = 1'b1;
        state_nxt    = S_R_BK;
      end
      S_R_BK: begin
        cmd.bk_stage = 1'b1;
        state_nxt    = S_R_RD;
      end
      S_R_RD: begin
        cmd.ctr_rd     = 1'b1;
        cmd.tot_rd     = 1'b1;
        cmd.hist_rd_bk = 1'b1;
        state_nxt      = S_R_WR;
      end
      S_R_WR: begin
        cmd.met_wr     = 1'b1;
        cmd.ctr_wr_rec = !second_r;
        if (!second_r && !sts.rec && sts.cont) begin
          second_nxt          = 1'b1;
          cmd.set_metric_wait = 1'b1;
          state_nxt           = S_R_BL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // trylock failure
      S_F_RD: begin
        cmd.ctr_rd = 1'b1;
        state_nxt  = S_F_WR;
      end
      S_F_WR: begin
        cmd.ctr_wr_fail = 1'b1;
        state_nxt       = S_IDLE;
      end
      // query
      S_Q_RD: begin
        cmd.ctr_rd    = 1'b1;
        cmd.tot_rd    = 1'b1;
        cmd.base_ld   = 1'b1;
        cmd.walk_init = 1'b1;
        state_nxt     = S_Q_LD;
      end
      S_Q_LD: begin
        cmd.hist_rd_walk = 1'b1;
        cmd.prod_ld      = 1'b1;
        state_nxt        = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (!sts.metric_ok || sts.cnt_zero) begin
          cmd.pct_zero = 1'b1;
          state_nxt    = S_Q_OUT;
        end else if (sts.huge) begin
          cmd.pct_max = 1'b1;
          state_nxt   = S_Q_OUT;
        end else begin
          state_nxt = S_W_ACC;
        end
      end
      S_W_ACC: begin
        cmd.walk_acc = 1'b1;
        state_nxt    = S_W_CMP;
      end
      S_W_CMP: begin
        if (sts.hit) begin
          cmd.pct_bucket = 1'b1;
          state_nxt      = S_Q_OUT;
        end else if (sts.bidx_last) begin
          cmd.pct_max = 1'b1;
          state_nxt   = S_Q_OUT;
        end else begin
          cmd.walk_next    = 1'b1;
          cmd.hist_rd_walk = 1'b1;
          state_nxt        = S_W_ACC;
        end
      end
      S_Q_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

@@ rtl/core/llst_dpath.sv @@
module llst_dpath
  import llst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  llst_cmd_t             cmd,
  output llst_sts_t             sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef struct packed {
    logic [DEPTH_W-1:0] dep;
    logic [NS_W-1:0]    fail;
    logic [NS_W-1:0]    cont;
    logic [NS_W-1:0]    rec;
    logic [NS_W-1:0]    outer;
    logic [NS_W-1:0]    acq;
  } ctr_word_t;

  typedef struct packed {
    logic [NS_W-1:0] max;
    logic [NS_W-1:0] sum;
    logic [NS_W-1:0] cnt;
  } tot_word_t;

  function automatic logic [3:0] byte_len(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  // captured transaction
  logic [OP_W-1:0]    op_r;
  logic [ROW_W-1:0]   row_r;
  logic [NS_W-1:0]    elapsed_r;
  logic [NS_W-1:0]    wait_r;
  logic [DEPTH_W-1:0] depth_r;
  logic               rec_r;
  logic               cont_r;
  logic [MSEL_W-1:0]  msel_r;
  logic [PCT_W-1:0]   pct_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_tuser;
      row_r     <= in_tdata[8:0];
      elapsed_r <= in_tdata[72:9];
      wait_r    <= in_tdata[136:73];
      depth_r   <= in_tdata[152:137];
      rec_r     <= in_tdata[153];
      cont_r    <= in_tdata[154];
      msel_r    <= in_tdata[156:155];
      pct_r     <= in_tdata[163:157];
    end
  end

  // metric being worked on
  logic [MSEL_W-1:0] metric_r;
  logic              metric_ok;

  always_ff @(posedge clk) begin
    if (cmd.set_metric_first) begin
      metric_r <= (op_r == OP_QUERY) ? msel_r : (rec_r ? MET_REC : MET_HOLD);
    end else if (cmd.set_metric_wait) begin
      metric_r <= MET_WAIT;
    end
  end

  assign metric_ok = (metric_r == MET_WAIT) || (metric_r == MET_HOLD) ||
                     (metric_r == MET_REC);

  // addressing
  logic              row_ok;
  logic [ROW_AW-1:0] row_idx;
  logic [SLOT_AW-1:0] slot_w;
  logic [NS_W-1:0]   sample_w;

  assign row_ok   = (32'(row_r) < ROWS);
  assign row_idx  = ROW_AW'(row_r);
  assign slot_w   = SLOT_AW'({row_idx, 1'b0}) + SLOT_AW'(row_idx) + SLOT_AW'(metric_r);
  assign sample_w = (metric_r == MET_WAIT) ? wait_r : elapsed_r;

  // bit length, stage one: per byte
  logic [3:0] blen_r   [8];
  logic [3:0] blen_nxt [8];
  logic [7:0] bnz_r, bnz_nxt;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      bnz_nxt[j]  = |sample_w[8*j +: 8];
      blen_nxt[j] = byte_len(sample_w[8*j +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bl_stage) begin
      blen_r <= blen_nxt;
      bnz_r  <= bnz_nxt;
    end
  end

  // bit length, stage two: highest non-zero byte, clamped to the last bucket
  logic [BLEN_W-1:0] bitlen_c;
  logic [BK_W-1:0]   bucket_r, bucket_nxt;

  always_comb begin
    bitlen_c = '0;
    for (int j = 0; j < 8; j++) begin
      if (bnz_r[j]) bitlen_c = BLEN_W'(j * 8) + BLEN_W'(blen_r[j]);
    end
    if (bitlen_c > BLEN_W'(BUCKETS - 1)) bucket_nxt = BK_W'(BUCKETS - 1);
    else                                 bucket_nxt = BK_W'(bitlen_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.bk_stage) bucket_r <= bucket_nxt;
  end

  // histogram base of the current row and metric
  logic [HIST_AW-1:0] hbase_r;

  always_ff @(posedge clk) begin
    if (cmd.base_ld) hbase_r <= HIST_AW'(slot_w) * HIST_AW'(BUCKETS);
  end

  // walk registers
  logic [NS_W-1:0]   seen_r;
  logic [BK_W-1:0]   bidx_r, bidx_inc;
  logic [PROD_W-1:0] prod_r;
  logic [NS_W-1:0]   pctl_r;
  logic [NS_W:0]     seen_sum;
  logic [PROD_W-1:0] seen100;
  logic [NS_W-1:0]   bucket_upper;

  assign bidx_inc = bidx_r + 1'b1;

  // histogram addresses
  logic [HIST_AW-1:0] hist_bk_addr, hist_rd_addr;

  assign hist_bk_addr = hbase_r + HIST_AW'(bucket_r);
  assign hist_rd_addr = cmd.hist_rd_walk ?
                        hbase_r + HIST_AW'(cmd.walk_next ? bidx_inc : bidx_r) :
                        hist_bk_addr;

  // memories
  ctr_word_t       ctr_mem  [ROWS];
  tot_word_t       tot_mem  [SLOTS];
  logic [NS_W-1:0] hist_mem [HDEPTH];

  ctr_word_t       ctr_q, ctr_upd;
  tot_word_t       tot_q, tot_upd;
  logic [NS_W-1:0] hist_q;

  // clearing pass counter
  logic [HIST_AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            clr_idx_r <= '0;
    else if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (cmd.ctr_rd) ctr_q <= ctr_mem[row_idx];
    if (cmd.tot_rd && metric_ok) tot_q <= tot_mem[slot_w];
    if ((cmd.hist_rd_bk || cmd.hist_rd_walk) && metric_ok) hist_q <= hist_mem[hist_rd_addr];
  end

  // counter update
  always_comb begin
    ctr_upd = ctr_q;
    if (cmd.ctr_wr_fail) begin
      ctr_upd.fail = ctr_q.fail + 1'b1;
    end else begin
      ctr_upd.acq = ctr_q.acq + 1'b1;
      if (ctr_q.dep < depth_r) ctr_upd.dep = depth_r;
      if (rec_r) begin
        ctr_upd.rec = ctr_q.rec + 1'b1;
      end else begin
        ctr_upd.outer = ctr_q.outer + 1'b1;
        if (cont_r) ctr_upd.cont = ctr_q.cont + 1'b1;
      end
    end
  end

  // metric totals update
  always_comb begin
    tot_upd     = tot_q;
    tot_upd.cnt = tot_q.cnt + 1'b1;
    tot_upd.sum = tot_q.sum + sample_w;
    if (tot_q.max < sample_w) tot_upd.max = sample_w;
  end

  // writes, shared with the clearing pass
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      if (clr_idx_r < HIST_AW'(ROWS)) ctr_mem[ROW_AW'(clr_idx_r)] <= '0;
    end else if (cmd.ctr_wr_rec || cmd.ctr_wr_fail) begin
      ctr_mem[row_idx] <= ctr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      if (clr_idx_r < HIST_AW'(SLOTS)) tot_mem[SLOT_AW'(clr_idx_r)] <= '0;
    end else if (cmd.met_wr) begin
      tot_mem[slot_w] <= tot_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      hist_mem[clr_idx_r] <= '0;
    end else if (cmd.met_wr) begin
      hist_mem[hist_bk_addr] <= hist_q + 1'b1;
    end
  end

  // percentile walk
  assign seen_sum = {1'b0, seen_r} + {1'b0, hist_q};
  assign seen100  = (PROD_W'(seen_r) << 6) + (PROD_W'(seen_r) << 5) +
                    (PROD_W'(seen_r) << 2);

  always_comb begin
    if (bidx_r == '0) begin
      bucket_upper = '0;
    end else if ((bidx_r == BK_W'(BUCKETS - 1)) || (32'(bidx_r) >= NS_W)) begin
      bucket_upper = '1;
    end else begin
      bucket_upper = ~({NS_W{1'b1}} << bidx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      seen_r <= '0;
      bidx_r <= '0;
    end else begin
      if (cmd.walk_acc)  seen_r <= seen_sum[NS_W] ? '1 : seen_sum[NS_W-1:0];
      if (cmd.walk_next) bidx_r <= bidx_inc;
    end
    if (cmd.prod_ld) prod_r <= PROD_W'(tot_q.cnt) * PROD_W'(pct_r);
    if (cmd.pct_zero)        pctl_r <= '0;
    else if (cmd.pct_max)    pctl_r <= tot_q.max;
    else if (cmd.pct_bucket) pctl_r <= bucket_upper;
  end

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  met_out_ok;

  assign met_out_ok = row_ok && metric_ok;

  always_comb begin
    if (!row_ok) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt = {met_out_ok ? pctl_r    : {NS_W{1'b0}},
                      met_out_ok ? tot_q.max : {NS_W{1'b0}},
                      met_out_ok ? tot_q.sum : {NS_W{1'b0}},
                      met_out_ok ? tot_q.cnt : {NS_W{1'b0}},
                      ctr_q.dep, ctr_q.fail, ctr_q.cont, ctr_q.rec,
                      ctr_q.outer, ctr_q.acq};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready)   out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status
  assign sts.clr_last  = (clr_idx_r == HIST_AW'(HDEPTH - 1));
  assign sts.op        = op_r;
  assign sts.row_ok    = row_ok;
  assign sts.rec       = rec_r;
  assign sts.cont      = cont_r;
  assign sts.metric_ok = metric_ok;
  assign sts.cnt_zero  = (tot_q.cnt == '0);
  assign sts.huge      = (prod_r > HUGE_LIM);
  assign sts.hit       = (seen100 >= prod_r);
  assign sts.bidx_last = (bidx_r == BK_W'(BUCKETS - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

@@ rtl/core/lock_latency_stats_table.sv @@
// channel | direction | payload
// --------+-----------+------------------------------------------------------------
// in_     | slave     | tuser: operation; tdata: row, hold_ns, wait_ns,
//         |           | nest_depth, is_recursive, was_contended, metric_select, percent
// out_    | master    | tdata: row counters, deepest, metric totals, percentile bound
//
// a record runs the bit-length, bucket, read and write steps once, and again when an
// outer contended hold also updates the wait metric; each metric pass is a
// read-modify-write on one port; a trylock failure reads then writes the row counters
// a query walks the histogram one bucket at a time, at most BUCKETS buckets
// after reset a clearing pass zeroes the memories, one entry per cycle, with in_tready
// low throughout
// a finished query waits in the output register; a stalled out_tready holds the next
// query and all input behind it, while records and trylock failures ahead of it go on
module lock_latency_stats_table
  import llst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // row, hold_ns, wait_ns, nest_depth, is_recursive, was_contended,
  // metric_select, percent (from bit 0 up, zero fill to 168 bits)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // acquisitions, outer_count, recursive_count, contended_count, try_failures,
  // deepest, sample_count, sum_ns, largest_ns, percentile_upper_ns (from bit 0 up)
  output logic [OUT_DATA_W-1:0] out_tdata
);

  llst_cmd_t cmd;
  llst_sts_t sts;

  // sequencer
  llst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table memories and arithmetic
  llst_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

@@ test/tb.sv @@
module tb;
  import llst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [MSEL_W-1:0] MET_NONE  = 2'd3;

  // row counter slots
  localparam int CTR_ACQ   = 0;
  localparam int CTR_OUTER = 1;
  localparam int CTR_REC   = 2;
  localparam int CTR_CONT  = 3;
  localparam int CTR_TRY   = 4;
  localparam int NCTR      = 5;

  localparam int RANDOM_OPS = 1750;
  localparam logic [NS_W-1:0] NS_ALL = {NS_W{1'b1}};

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [NS_W-1:0]    elapsed;
    logic [NS_W-1:0]    wait_ns;
    logic [DEPTH_W-1:0] depth;
    logic               rec;
    logic               cont;
    logic [MSEL_W-1:0]  msel;
    logic [PCT_W-1:0]   pct;
  } lock_op_t;

  // last field sits in the lowest bits
  typedef struct packed {
    logic [NS_W-1:0]    pct_upper;
    logic [NS_W-1:0]    largest;
    logic [NS_W-1:0]    sum;
    logic [NS_W-1:0]    samples;
    logic [DEPTH_W-1:0] deepest;
    logic [NS_W-1:0]    try_fail;
    logic [NS_W-1:0]    contended;
    logic [NS_W-1:0]    recursive;
    logic [NS_W-1:0]    outer;
    logic [NS_W-1:0]    acq;
  } row_report_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // row, hold_ns, wait_ns, nest_depth, is_recursive, was_contended,
  // metric_select, percent (from bit 0 up, zero fill)
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // operation
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  // acquisitions, outer_count, recursive_count, contended_count, try_failures,
  // deepest, sample_count, sum_ns, largest_ns, percentile_upper_ns (from bit 0 up)
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow copy of the statistics table
  bit [NS_W-1:0]    ctr_tab   [ROWS][NCTR];
  bit [DEPTH_W-1:0] depth_tab [ROWS];
  bit [NS_W-1:0]    cnt_tab   [ROWS][NMET];
  bit [NS_W-1:0]    sum_tab   [ROWS][NMET];
  bit [NS_W-1:0]    max_tab   [ROWS][NMET];
  bit [NS_W-1:0]    hist_tab  [ROWS][NMET][BUCKETS];

  lock_op_t    pending_ops[$];
  row_report_t expected_reports[$];
  lock_op_t    cur_op;
  int          total_ops    = 0;
  int          accepted_ops = 0;
  int          mismatch_cnt = 0;
  int          idle_left    = 0;
  int          stall_left   = 0;
  int unsigned cycle_no     = 0;
  int          hot_rows[8];

  lock_latency_stats_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one line per mismatch
  task automatic flag_mismatch(input string what, input logic [NS_W-1:0] got,
                               input logic [NS_W-1:0] want);
    mismatch_cnt++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [NS_W-1:0] got,
                             input logic [NS_W-1:0] want);
    if (got !== want) begin
      flag_mismatch(what, got, want);
    end
  endtask

  // gap length: mostly short, a few long, none during calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_no / 400) % 5 == 4) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // histogram bucket: bit length of the sample, capped at the last bucket
  function automatic int bucket_index(input bit [NS_W-1:0] v);
    int n;
    n = 0;
    while (v != 0 && n + 1 < BUCKETS) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  task automatic add_sample(input int r, input int m, input bit [NS_W-1:0] v);
    cnt_tab[r][m] += 1;
    sum_tab[r][m] += v;
    if (max_tab[r][m] < v) max_tab[r][m] = v;
    hist_tab[r][m][bucket_index(v)] += 1;
  endtask

  // upper bound of the bucket where the cumulative count reaches the target
  function automatic bit [NS_W-1:0] percentile_bound(input int r, input int m,
                                                     input bit [PCT_W-1:0] pct);
    bit [71:0]     goal;
    bit [NS_W-1:0] seen;
    bit [NS_W-1:0] b;
    if (cnt_tab[r][m] == 0) return '0;
    goal = (72'(cnt_tab[r][m]) * 72'(pct) + 72'd99) / 72'd100;
    if (goal > 72'(NS_ALL)) return max_tab[r][m];
    seen = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      b = hist_tab[r][m][i];
      seen = (seen > ~b) ? NS_ALL : seen + b;
      if (72'(seen) >= goal) begin
        if (i == 0) return '0;
        if (i + 1 == BUCKETS || i >= 64) return NS_ALL;
        return (64'd1 << i) - 64'd1;
      end
    end
    return max_tab[r][m];
  endfunction

  // apply one accepted transaction to the shadow table
  task automatic update_table(input lock_op_t t);
    row_report_t rep;
    int          r;
    int          m;
    r = int'(t.row);
    case (t.op)
      OP_RECORD: begin
        if (r < ROWS) begin
          ctr_tab[r][CTR_ACQ] += 1;
          if (depth_tab[r] < t.depth) depth_tab[r] = t.depth;
          if (t.rec) begin
            ctr_tab[r][CTR_REC] += 1;
            add_sample(r, int'(MET_REC), t.elapsed);
          end else begin
            ctr_tab[r][CTR_OUTER] += 1;
            add_sample(r, int'(MET_HOLD), t.elapsed);
            if (t.cont) begin
              ctr_tab[r][CTR_CONT] += 1;
              add_sample(r, int'(MET_WAIT), t.wait_ns);
            end
          end
        end
      end
      OP_TRYFAIL: begin
        if (r < ROWS) ctr_tab[r][CTR_TRY] += 1;
      end
      OP_QUERY: begin
        rep = '0;
        if (r < ROWS) begin
          rep.acq       = ctr_tab[r][CTR_ACQ];
          rep.outer     = ctr_tab[r][CTR_OUTER];
          rep.recursive = ctr_tab[r][CTR_REC];
          rep.contended = ctr_tab[r][CTR_CONT];
          rep.try_fail  = ctr_tab[r][CTR_TRY];
          rep.deepest   = depth_tab[r];
          if (int'(t.msel) < NMET) begin
            m = int'(t.msel);
            rep.samples   = cnt_tab[r][m];
            rep.sum       = sum_tab[r][m];
            rep.largest   = max_tab[r][m];
            rep.pct_upper = percentile_bound(r, m, t.pct);
          end
        end
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic queue_op(input logic [OP_W-1:0] op, input int row,
                          input logic [NS_W-1:0] elapsed, input logic [NS_W-1:0] wait_ns,
                          input int depth, input bit rec, input bit cont,
                          input logic [MSEL_W-1:0] msel, input int pct);
    lock_op_t t;
    t.op      = op;
    t.row     = ROW_W'(row);
    t.elapsed = elapsed;
    t.wait_ns = wait_ns;
    t.depth   = DEPTH_W'(depth);
    t.rec     = rec;
    t.cont    = cont;
    t.msel    = msel;
    t.pct     = PCT_W'(pct);
    pending_ops.push_back(t);
  endtask

  // sample with a random bit length, so every bucket gets hit
  function automatic logic [NS_W-1:0] rand_ns();
    int            blen;
    logic [NS_W-1:0] v;
    blen = $urandom_range(0, 64);
    if (blen == 0) return '0;
    v = {$urandom, $urandom};
    if (blen < 64) v = v & ((64'd1 << blen) - 64'd1);
    v[blen-1] = 1'b1;
    return v;
  endfunction

  function automatic int pick_row();
    if ($urandom_range(0, 99) < 85) return hot_rows[$urandom_range(0, 7)];
    return $urandom_range(0, ROWS - 1);
  endfunction

  function automatic int pick_pct();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 100;
    if (r == 2) return $urandom_range(101, 127);
    return $urandom_range(0, 100);
  endfunction

  // driver: presents queued transactions, random gaps in between
  always @(posedge clk) begin : op_driver
    logic fire;
    fire = in_tvalid && in_tready;
    cycle_no++;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        update_table(cur_op);
        accepted_ops++;
      end
      if (!in_tvalid || fire) begin
        if (idle_left > 0) begin
          idle_left--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          in_tdata  <= {4'b0, cur_op.pct, cur_op.msel, cur_op.cont, cur_op.rec,
                        cur_op.depth, cur_op.wait_ns, cur_op.elapsed, cur_op.row};
          in_tuser  <= cur_op.op;
          in_tvalid <= 1'b1;
          idle_left = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction, stalls the output at random
  always @(posedge clk) begin : report_monitor
    row_report_t got;
    row_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected result", got.acq, '0);
      end else begin
        want = expected_reports.pop_front();
        check_field("acquisitions", got.acq, want.acq);
        check_field("outer_count", got.outer, want.outer);
        check_field("recursive_count", got.recursive, want.recursive);
        check_field("contended_count", got.contended, want.contended);
        check_field("try_failures", got.try_fail, want.try_fail);
        check_field("deepest", NS_W'(got.deepest), NS_W'(want.deepest));
        check_field("sample_count", got.samples, want.samples);
        check_field("sum_ns", got.sum, want.sum);
        check_field("largest_ns", got.largest, want.largest);
        check_field("percentile_upper_ns", got.pct_upper, want.pct_upper);
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
    end
  end

  // stimulus and end of run
  initial begin
    int counted;
    int r;
    int row;
    int guard;

    hot_rows[0] = 0;
    hot_rows[1] = ROWS - 1;
    for (int i = 2; i < 8; i++) hot_rows[i] = $urandom_range(0, ROWS - 1);

    // directed: empty metric, bucket extremes, every operation and metric
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_WAIT, 50);
    queue_op(OP_RECORD,  0, '0, NS_ALL, 1, 0, 1, MET_WAIT, 0);
    queue_op(OP_RECORD,  0, NS_ALL, '0, 65535, 0, 1, MET_WAIT, 0);
    queue_op(OP_RECORD,  0, 64'd5, NS_ALL, 2, 1, 1, MET_WAIT, 0);
    queue_op(OP_RECORD,  0, 64'h8000_0000_0000_0000, '0, 3, 1, 0, MET_WAIT, 0);
    queue_op(OP_TRYFAIL, 0, '0, '0, 1, 0, 0, MET_WAIT, 0);
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_HOLD, 0);
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_HOLD, 100);
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_WAIT, 50);
    // percent above one hundred falls back to the largest sample
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_REC, 127);
    // unknown metric select
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_NONE, 50);
    // unknown operation is dropped
    queue_op(OP_UNUSED,  0, NS_ALL, NS_ALL, 65535, 1, 1, MET_NONE, 127);
    queue_op(OP_RECORD,  ROWS - 1, 64'd1, '0, 65535, 0, 0, MET_WAIT, 0);
    queue_op(OP_TRYFAIL, ROWS - 1, '0, '0, 1, 0, 0, MET_WAIT, 0);
    queue_op(OP_TRYFAIL, ROWS - 1, '0, '0, 1, 0, 0, MET_WAIT, 0);
    queue_op(OP_QUERY,   ROWS - 1, '0, '0, 1, 0, 0, MET_HOLD, 1);
    queue_op(OP_QUERY,   ROWS - 1, '0, '0, 1, 0, 0, MET_WAIT, 100);
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_HOLD, 101);
    queue_op(OP_QUERY,   0, '0, '0, 1, 0, 0, MET_REC, 50);

    // random: mostly records and queries on a few hot rows, all fields noisy
    counted = 0;
    while (counted < RANDOM_OPS) begin
      r   = $urandom_range(0, 99);
      row = pick_row();
      if (r < 55) begin
        queue_op(OP_RECORD, row, rand_ns(), rand_ns(),
                 ($urandom_range(0, 9) < 7) ? $urandom_range(1, 64) : $urandom_range(1, 65535),
                 $urandom_range(0, 9) < 3, 1'($urandom_range(0, 1)),
                 MSEL_W'($urandom_range(0, 3)), $urandom_range(0, 127));
        counted++;
      end else if (r < 67) begin
        queue_op(OP_TRYFAIL, row, rand_ns(), rand_ns(), $urandom_range(1, 65535),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 MSEL_W'($urandom_range(0, 3)), $urandom_range(0, 127));
        counted++;
      end else if (r < 95) begin
        queue_op(OP_QUERY, row, rand_ns(), rand_ns(), $urandom_range(1, 65535),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 99) < 92) ? MSEL_W'($urandom_range(0, 2)) : MET_NONE,
                 pick_pct());
        counted++;
      end else begin
        queue_op(OP_UNUSED, row, rand_ns(), rand_ns(), $urandom_range(1, 65535),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 MSEL_W'($urandom_range(0, 3)), $urandom_range(0, 127));
        counted++;
      end
    end
    total_ops = pending_ops.size();

    // synchronous reset
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted_ops == total_ops);

    // drain outstanding results
    guard = 0;
    while (expected_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_reports.size() != 0) begin
      flag_mismatch("missing results", NS_W'(expected_reports.size()), '0);
    end
    repeat (200) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
